// File: rtl/tpas_pkg.sv
// Shared widths, constants and control types for the trace peak amplitude and SNR block.
`default_nettype none

package tpas_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int INDEX_W       = 16;
    localparam int SNR_W         = 32;
    localparam int FRAC_BITS     = 8;
    localparam int MAX_TRACE_LEN = 65536;
    localparam int DIV_STEPS     = SNR_W;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam logic [INDEX_W-1:0] MAX_INDEX  = INDEX_W'(MAX_TRACE_LEN - 1);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(DIV_STEPS - 1);
    localparam logic [SNR_W-1:0]   SNR_SAT    = {SNR_W{1'b1}};

    typedef struct packed {
        logic sample_take;
        logic trace_end;
        logic div_step;
        logic out_load;
    } tpas_cmd_t;

    typedef struct packed {
        logic div_last;
    } tpas_sts_t;

endpackage

`default_nettype wire

// File: rtl/tpas_in_if.sv
// Sample channel: valid/ready handshake carrying one trace sample and its end-of-trace flag.
`default_nettype none

interface tpas_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tpas_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/tpas_out_if.sv
// Result channel: valid/ready handshake carrying peak amplitude, position and SNR.
`default_nettype none

interface tpas_out_if;
    logic                          valid;
    logic                          ready;
    logic [tpas_pkg::SAMPLE_W-1:0] amplitude;
    logic [tpas_pkg::INDEX_W-1:0]  peak_position;
    logic [tpas_pkg::SNR_W-1:0]    snr;
    logic                          noise_zero;

    modport source (output valid, output amplitude, output peak_position, output snr,
                    output noise_zero, input ready);
    modport sink (input valid, input amplitude, input peak_position, input snr,
                  input noise_zero, output ready);
endinterface

`default_nettype wire

// File: rtl/tpas_ctrl.sv
// Controller: sample intake, serial divide sequencing and result register handshake.
`default_nettype none

module tpas_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire tpas_pkg::tpas_sts_t sts,
    output tpas_pkg::tpas_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_RUN);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd.sample_take = 1'b0;
        cmd.trace_end   = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.out_load    = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                cmd.sample_take = in_valid;
                cmd.trace_end   = in_valid && in_last;
                if (in_valid && in_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tpas_dp.sv
// Datapath: onset register, noise and signal peak trackers, restoring divider, result register.
`default_nettype none

module tpas_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [tpas_pkg::INDEX_W-1:0]         cfg_data,
    input  wire logic signed [tpas_pkg::SAMPLE_W-1:0] sample,
    input  wire tpas_pkg::tpas_cmd_t                  cmd,
    output tpas_pkg::tpas_sts_t                       sts,
    output logic [tpas_pkg::SAMPLE_W-1:0]             amplitude,
    output logic [tpas_pkg::INDEX_W-1:0]              peak_position,
    output logic [tpas_pkg::SNR_W-1:0]                snr,
    output logic                                      noise_zero
);

    localparam int SW = tpas_pkg::SAMPLE_W;
    localparam int IW = tpas_pkg::INDEX_W;
    localparam int QW = tpas_pkg::SNR_W;

    logic [IW-1:0] onset_reg;
    logic [IW-1:0] count_reg;
    logic [SW-1:0] noise_reg;
    logic [SW-1:0] sig_reg;
    logic [IW-1:0] sig_idx_reg;

    logic [SW-1:0] amp_reg;
    logic [IW-1:0] pos_reg;
    logic [QW-1:0] quot_reg;
    logic [SW-1:0] divisor_reg;
    logic [SW-1:0] rem_reg;
    logic [tpas_pkg::STEP_W-1:0] step_reg;

    logic [SW-1:0] out_amp_reg;
    logic [IW-1:0] out_pos_reg;
    logic [QW-1:0] out_snr_reg;
    logic          out_nz_reg;

    logic [SW-1:0] sample_u;
    logic [SW-1:0] mag;
    logic          is_noise;
    logic          sig_hit;
    logic [SW-1:0] noise_next;
    logic [SW-1:0] sig_next;
    logic [IW-1:0] sig_idx_next;
    logic [IW-1:0] count_next;

    logic [SW:0]   rem_shift;
    logic [SW+1:0] diff;
    logic          fits;
    logic [SW-1:0] rem_next;
    logic [QW-1:0] quot_next;
    logic [QW-1:0] quot_final;

    assign sample_u = SW'(unsigned'(sample));
    assign mag      = sample_u[SW-1] ? (~sample_u + SW'(1)) : sample_u;
    assign is_noise = (count_reg < onset_reg);
    assign sig_hit  = !is_noise && (mag > sig_reg);

    assign noise_next   = (is_noise && (mag > noise_reg)) ? mag : noise_reg;
    assign sig_next     = sig_hit ? mag : sig_reg;
    assign sig_idx_next = sig_hit ? count_reg : sig_idx_reg;
    assign count_next   = (count_reg == tpas_pkg::MAX_INDEX) ? count_reg : count_reg + IW'(1);

    assign rem_shift = {rem_reg, quot_reg[QW-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, divisor_reg};
    assign fits      = !diff[SW+1];
    assign rem_next  = fits ? diff[SW-1:0] : rem_shift[SW-1:0];
    assign quot_next = {quot_reg[QW-2:0], fits};
    assign quot_final = cmd.div_step ? quot_next : quot_reg;

    assign sts.div_last = (step_reg == tpas_pkg::LAST_STEP);

    assign amplitude     = out_amp_reg;
    assign peak_position = out_pos_reg;
    assign snr           = out_snr_reg;
    assign noise_zero    = out_nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            onset_reg <= '0;
            count_reg <= '0;
            noise_reg <= '0;
            sig_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                onset_reg <= cfg_data;
            end
            if (cmd.trace_end)
            begin
                count_reg <= '0;
                noise_reg <= '0;
                sig_reg   <= '0;
                step_reg  <= '0;
            end
            else
            begin
                if (cmd.sample_take)
                begin
                    count_reg <= count_next;
                    noise_reg <= noise_next;
                    sig_reg   <= sig_next;
                end
                if (cmd.div_step)
                begin
                    step_reg <= step_reg + tpas_pkg::STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_take)
        begin
            sig_idx_reg <= sig_idx_next;
        end
        if (cmd.trace_end)
        begin
            amp_reg     <= sig_next;
            pos_reg     <= (sig_next != '0) ? sig_idx_next : onset_reg;
            quot_reg    <= QW'({sig_next, {tpas_pkg::FRAC_BITS{1'b0}}});
            divisor_reg <= noise_next;
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        if (cmd.out_load)
        begin
            out_amp_reg <= amp_reg;
            out_pos_reg <= pos_reg;
            out_nz_reg  <= (divisor_reg == '0);
            out_snr_reg <= (divisor_reg == '0) ? tpas_pkg::SNR_SAT : quot_final;
        end
    end

endmodule

`default_nettype wire

// File: rtl/trace_peak_amplitude_snr_core.sv
// Top level of the trace peak amplitude and SNR block.
//
// samples: one signed 24-bit trace sample per item, last marks the final one.
// results: one item per trace with amplitude, peak_position, snr (Q24.8) and
//          noise_zero. The user must write onset_index with cfg_we/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Samples before onset_index set the noise peak, later ones the signal peak.
// Throughput: one sample per cycle within a trace. On the last sample the
// block runs a restoring divider, one quotient bit per cycle; the result
// is loaded into the output register when the last bit is done, and samples
// is not ready while the divider runs.
// The result sits in an output register; a new trace is taken while it waits.
// If the receiver still holds the previous result when the next quotient is
// done, the block holds the quotient and keeps samples stalled until the
// output register frees up.
// Reset clears onset_index to 0, the trace state and the output valid flag.
`default_nettype none

module trace_peak_amplitude_snr_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [tpas_pkg::INDEX_W-1:0] cfg_data,
    tpas_in_if.sink                           samples,
    tpas_out_if.source                        results
);

    tpas_pkg::tpas_cmd_t cmd;
    tpas_pkg::tpas_sts_t sts;

    tpas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.last),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tpas_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .sample        (samples.sample),
        .cmd           (cmd),
        .sts           (sts),
        .amplitude     (results.amplitude),
        .peak_position (results.peak_position),
        .snr           (results.snr),
        .noise_zero    (results.noise_zero)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready && samples.last |=> !samples.ready)
        else $error("samples accepted while divider busy");

    a_nz_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.noise_zero |-> results.snr == tpas_pkg::SNR_SAT)
        else $error("zero noise peak without saturated snr");

    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.amplitude <= 24'h800000)
        else $error("amplitude out of range");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sample_take && cmd.div_step))
        else $error("sample taken during divide");
`endif

endmodule

`default_nettype wire
